[design/m68k_line4_opcode_decoder_defines.svh]
// Assertion macros for the line-4 opcode decoder RTL.
`ifndef M68K_LINE4_OPCODE_DECODER_DEFINES_SVH
`define M68K_LINE4_OPCODE_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// Clocked check, masked while reset is asserted.
`define M68KL4_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define M68KL4_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define M68KL4_ASSERT(name, prop, msg)
`define M68KL4_ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

[design/m68kl4_pkg.sv]
// Types and opcode constants for the line-4 opcode decoder.
`timescale 1ns / 1ps

package m68kl4_pkg;

	// Instruction classes as presented on the result channel
	typedef enum logic [4:0] {
		CLS_ILLEGAL       = 5'd0,
		CLS_LEA           = 5'd1,
		CLS_NEGX          = 5'd2,
		CLS_MOVE_FROM_SR  = 5'd3,
		CLS_CLR           = 5'd4,
		CLS_NEG           = 5'd5,
		CLS_MOVE_TO_CCR   = 5'd6,
		CLS_MOVE_TO_SR    = 5'd7,
		CLS_NOT           = 5'd8,
		CLS_SWAP          = 5'd9,
		CLS_PEA           = 5'd10,
		CLS_NBCD          = 5'd11,
		CLS_EXT           = 5'd12,
		CLS_MOVEM_TO_MEM  = 5'd13,
		CLS_TAS           = 5'd14,
		CLS_TST           = 5'd15,
		CLS_MOVEM_TO_REGS = 5'd16,
		CLS_TRAP          = 5'd17,
		CLS_NOP           = 5'd18,
		CLS_RTE           = 5'd19,
		CLS_RTS           = 5'd20,
		CLS_TRAPV         = 5'd21,
		CLS_LINK          = 5'd22,
		CLS_UNLK          = 5'd23,
		CLS_MOVE_TO_USP   = 5'd24,
		CLS_MOVE_FROM_USP = 5'd25,
		CLS_JMP           = 5'd26,
		CLS_JSR           = 5'd27,
		CLS_HOST_CALL     = 5'd28
	} instr_class_t;

	// High-byte groups of line 4
	localparam logic [3:0] LINE_MISC   = 4'h4;
	localparam logic [7:0] HI_NEGX     = 8'h40;
	localparam logic [7:0] HI_CLR      = 8'h42;
	localparam logic [7:0] HI_NEG      = 8'h44;
	localparam logic [7:0] HI_NOT      = 8'h46;
	localparam logic [7:0] HI_MISC     = 8'h48;
	localparam logic [7:0] HI_TST      = 8'h4A;
	localparam logic [7:0] HI_MOVEM_RD = 8'h4C;
	localparam logic [7:0] HI_CTRL     = 8'h4E;

	// Full low bytes of the fixed control words
	localparam logic [7:0] LO_NOP   = 8'h71;
	localparam logic [7:0] LO_RTE   = 8'h73;
	localparam logic [7:0] LO_RTS   = 8'h75;
	localparam logic [7:0] LO_TRAPV = 8'h76;

	// Low-byte prefixes (bits 7..3, or 7..4 for TRAP)
	localparam logic [4:0] LO_SWAP_PFX     = 5'b01000;
	localparam logic [4:0] LO_LINK_PFX     = 5'b01010;
	localparam logic [4:0] LO_UNLK_PFX     = 5'b01011;
	localparam logic [4:0] LO_TO_USP_PFX   = 5'b01100;
	localparam logic [4:0] LO_FROM_USP_PFX = 5'b01101;
	localparam logic [3:0] LO_TRAP_PFX     = 4'h4;
	localparam logic [3:0] TRAP_HOST       = 4'hF;

	// Size, mode and register codes that steer the decode
	localparam logic [1:0] SZ_BYTE   = 2'd0;
	localparam logic [1:0] SZ_WORD   = 2'd1;
	localparam logic [1:0] SZ_LONG   = 2'd2;
	localparam logic [1:0] SZ_SPEC   = 2'd3;
	localparam logic [2:0] MODE_DN   = 3'd0;
	localparam logic [2:0] MODE_AN   = 3'd1;
	localparam logic [2:0] MODE_EXT  = 3'd7;
	localparam logic [2:0] REG_ABS_L = 3'd1;

	// One decoded result
	typedef struct packed {
		instr_class_t instr_class;
		logic [1:0]   size_code;
		logic [2:0]   ea_mode;
		logic [2:0]   ea_reg;
		logic [2:0]   dest_reg;
		logic         long_form;
		logic [3:0]   trap_number;
		logic         privilege_violation;
	} result_t;

endpackage

[design/m68kl4_if.sv]
// Valid/ready channel interfaces for opcode words and decoded results.
`timescale 1ns / 1ps

interface m68kl4_op_if;
	logic        valid;
	logic        ready;
	logic [15:0] opcode;
	logic        supervisor;

	modport source(output valid, output opcode, output supervisor, input ready);
	modport sink(input valid, input opcode, input supervisor, output ready);
endinterface

interface m68kl4_res_if;
	logic       valid;
	logic       ready;
	logic [4:0] instr_class;
	logic [1:0] size_code;
	logic [2:0] ea_mode;
	logic [2:0] ea_reg;
	logic [2:0] dest_reg;
	logic       long_form;
	logic [3:0] trap_number;
	logic       privilege_violation;

	modport source(output valid, output instr_class, output size_code, output ea_mode,
		output ea_reg, output dest_reg, output long_form, output trap_number,
		output privilege_violation, input ready);
	modport sink(input valid, input instr_class, input size_code, input ea_mode,
		input ea_reg, input dest_reg, input long_form, input trap_number,
		input privilege_violation, output ready);
endinterface

[design/m68kl4_decode.sv]
// Combinational classifier and field extractor for one line-4 opcode word.
`timescale 1ns / 1ps

module m68kl4_decode
	import m68kl4_pkg::*;
(
	input  logic [15:0] opcode,
	input  logic        supervisor,
	output result_t     result
);

	logic [7:0]   hi;
	logic [7:0]   lo;
	logic [1:0]   sz;
	logic [2:0]   mode;
	logic [2:0]   rn;
	instr_class_t cls;
	logic         use_size;
	logic         use_mode;
	logic         use_reg;
	logic         use_dest;
	logic         use_long;
	logic         use_trap;
	logic         privileged;

	assign hi   = opcode[15:8];
	assign lo   = opcode[7:0];
	assign sz   = lo[7:6];
	assign mode = lo[5:3];
	assign rn   = lo[2:0];

	// Classify: LEA wins over the high-byte dispatch
	always_comb begin
		cls = CLS_ILLEGAL;
		if (hi[7:4] == LINE_MISC) begin
			if (hi[0] && sz == SZ_SPEC) begin
				cls = CLS_LEA;
			end else begin
				case (hi)
					HI_NEGX: cls = (sz != SZ_SPEC) ? CLS_NEGX : CLS_MOVE_FROM_SR;
					HI_CLR:  cls = (sz != SZ_SPEC) ? CLS_CLR : CLS_ILLEGAL;
					HI_NEG:  cls = (sz != SZ_SPEC) ? CLS_NEG : CLS_MOVE_TO_CCR;
					HI_NOT:  cls = (sz == SZ_SPEC) ? CLS_MOVE_TO_SR : CLS_NOT;
					HI_MISC: begin
						if (sz == SZ_WORD) begin
							cls = (lo[7:3] == LO_SWAP_PFX) ? CLS_SWAP : CLS_PEA;
						end else if (sz == SZ_BYTE) begin
							cls = (mode == MODE_AN) ? CLS_ILLEGAL : CLS_NBCD;
						end else if (mode == MODE_DN) begin
							cls = CLS_EXT;
						end else begin
							cls = CLS_MOVEM_TO_MEM;
						end
					end
					HI_TST: begin
						if (sz != SZ_SPEC) begin
							cls = CLS_TST;
						end else if (mode == MODE_AN || (mode == MODE_EXT && rn > REG_ABS_L)) begin
							cls = CLS_ILLEGAL;
						end else begin
							cls = CLS_TAS;
						end
					end
					HI_MOVEM_RD: cls = lo[7] ? CLS_MOVEM_TO_REGS : CLS_ILLEGAL;
					HI_CTRL: begin
						if (lo[7:4] == LO_TRAP_PFX) begin
							cls = (lo[3:0] == TRAP_HOST) ? CLS_HOST_CALL : CLS_TRAP;
						end else if (lo == LO_NOP) begin
							cls = CLS_NOP;
						end else if (lo == LO_RTE) begin
							cls = CLS_RTE;
						end else if (lo == LO_RTS) begin
							cls = CLS_RTS;
						end else if (lo == LO_TRAPV) begin
							cls = CLS_TRAPV;
						end else if (lo[7:3] == LO_LINK_PFX) begin
							cls = CLS_LINK;
						end else if (lo[7:3] == LO_UNLK_PFX) begin
							cls = CLS_UNLK;
						end else if (lo[7:3] == LO_TO_USP_PFX) begin
							cls = CLS_MOVE_TO_USP;
						end else if (lo[7:3] == LO_FROM_USP_PFX) begin
							cls = CLS_MOVE_FROM_USP;
						end else if (sz == SZ_SPEC) begin
							cls = CLS_JMP;
						end else if (sz == SZ_LONG) begin
							cls = CLS_JSR;
						end else begin
							cls = CLS_ILLEGAL;
						end
					end
					default: cls = CLS_ILLEGAL;
				endcase
			end
		end
	end

	// Select which opcode fields each class passes on
	always_comb begin
		use_size = 1'b0;
		use_mode = 1'b0;
		use_reg  = 1'b0;
		use_dest = 1'b0;
		use_long = 1'b0;
		use_trap = 1'b0;
		case (cls)
			CLS_LEA: begin
				use_mode = 1'b1;
				use_reg  = 1'b1;
				use_dest = 1'b1;
			end
			CLS_NEGX, CLS_CLR, CLS_NEG, CLS_NOT, CLS_TST: begin
				use_size = 1'b1;
				use_mode = 1'b1;
				use_reg  = 1'b1;
			end
			CLS_MOVE_FROM_SR, CLS_MOVE_TO_CCR, CLS_MOVE_TO_SR, CLS_PEA, CLS_NBCD,
			CLS_TAS, CLS_JMP, CLS_JSR: begin
				use_mode = 1'b1;
				use_reg  = 1'b1;
			end
			CLS_SWAP, CLS_LINK, CLS_UNLK, CLS_MOVE_TO_USP, CLS_MOVE_FROM_USP: begin
				use_reg = 1'b1;
			end
			CLS_EXT: begin
				use_reg  = 1'b1;
				use_long = 1'b1;
			end
			CLS_MOVEM_TO_MEM, CLS_MOVEM_TO_REGS: begin
				use_mode = 1'b1;
				use_reg  = 1'b1;
				use_long = 1'b1;
			end
			CLS_TRAP, CLS_HOST_CALL: begin
				use_trap = 1'b1;
			end
			default: begin
				use_size = 1'b0;
			end
		endcase
	end

	// Flag supervisor-only classes outside supervisor mode
	assign privileged = (cls == CLS_MOVE_TO_SR) || (cls == CLS_RTE) ||
		(cls == CLS_MOVE_TO_USP) || (cls == CLS_MOVE_FROM_USP);

	// Gather the result, zeroing unused fields
	always_comb begin
		result.instr_class         = cls;
		result.size_code           = use_size ? sz : 2'd0;
		result.ea_mode             = use_mode ? mode : 3'd0;
		result.ea_reg              = use_reg ? rn : 3'd0;
		result.dest_reg            = use_dest ? opcode[11:9] : 3'd0;
		result.long_form           = use_long ? lo[6] : 1'b0;
		result.trap_number         = use_trap ? lo[3:0] : 4'd0;
		result.privilege_violation = privileged && !supervisor;
	end

endmodule

[design/m68k_line4_opcode_decoder.sv]
// Top level of the line-4 (0x4xxx) opcode decoder with registered channels.
`timescale 1ns / 1ps
`include "m68k_line4_opcode_decoder_defines.svh"

// Decodes one 68000 opcode word from the miscellaneous group per transfer into an
// instruction class plus its operand fields; words outside line 4 and unsupported
// encodings give the illegal class with all fields zero. Throughput is one word per
// clock unless the result channel stalls: the word is captured in an input register,
// classified by a single combinational decode, and the result is held in an output
// register. Both stages advance together whenever the result register is empty or
// being taken, so a stalled result blocks new words only once both stages are full.

module m68k_line4_opcode_decoder
	import m68kl4_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	m68kl4_op_if.sink          op,
	m68kl4_res_if.source       res
);

	logic        valid_s1;
	logic [15:0] opcode_s1;
	logic        supervisor_s1;
	logic        valid_s2;
	result_t     result_s2;
	result_t     decoded;
	logic        advance_s2;
	logic        advance_s1;

	// Advance the output stage when it is empty or its transfer completes
	assign advance_s2 = !valid_s2 || res.ready;
	assign advance_s1 = !valid_s1 || advance_s2;
	assign op.ready   = advance_s1;

	// Hold the opcode word between input register and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance_s1) begin
				valid_s1 <= op.valid;
			end
			if (advance_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && op.valid) begin
			opcode_s1     <= op.opcode;
			supervisor_s1 <= op.supervisor;
		end
		if (advance_s2 && valid_s1) begin
			result_s2 <= decoded;
		end
	end

	m68kl4_decode u_decode (
		.opcode     (opcode_s1),
		.supervisor (supervisor_s1),
		.result     (decoded)
	);

	// Drive the result channel from the output register
	assign res.valid               = valid_s2;
	assign res.instr_class         = result_s2.instr_class;
	assign res.size_code           = result_s2.size_code;
	assign res.ea_mode             = result_s2.ea_mode;
	assign res.ea_reg              = result_s2.ea_reg;
	assign res.dest_reg            = result_s2.dest_reg;
	assign res.long_form           = result_s2.long_form;
	assign res.trap_number         = result_s2.trap_number;
	assign res.privilege_violation = result_s2.privilege_violation;

	// Checks on the two-stage flow and the decoded result
	`M68KL4_ASSERT(a_accept_fills_s1, (op.valid && op.ready) |=> valid_s1, "accepted word not captured")
	`M68KL4_ASSERT(a_s1_moves_to_s2, (valid_s1 && advance_s2) |=> res.valid, "decoded word dropped")
	`M68KL4_ASSERT(a_illegal_zero, (res.valid && res.instr_class == CLS_ILLEGAL) |-> (res.size_code == 2'd0 && res.ea_mode == 3'd0 && res.ea_reg == 3'd0 && res.dest_reg == 3'd0 && !res.long_form && res.trap_number == 4'd0 && !res.privilege_violation), "illegal class with nonzero field")
	`M68KL4_ASSERT(a_priv_class, (res.valid && res.privilege_violation) |-> (res.instr_class == CLS_MOVE_TO_SR || res.instr_class == CLS_RTE || res.instr_class == CLS_MOVE_TO_USP || res.instr_class == CLS_MOVE_FROM_USP), "privilege flag on unprivileged class")
	`M68KL4_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> (!valid_s1 && !res.valid), "pipeline not empty in reset")

endmodule
